// File: hdl/hdmms_pkg.sv
// Package for the hourly/daily min/max/average statistics core.
// Holds widths, reset constants and shared types; no dependencies.
package hdmms_pkg;
  localparam int TW = 15;
  localparam int HW = 14;
  localparam int HOUR_SLOTS_DEF = 64;
  localparam int DAY_SLOTS_DEF = 24;
  localparam logic [6:0] ROLLUP_RESET = 7'd60;
  localparam int MIN_START = 9999;

  typedef struct packed {
    logic signed [TW-1:0] temp;
    logic [HW-1:0] hum;
    logic roll;
  } job_t;

  typedef struct packed {
    logic signed [TW-1:0] tmax;
    logic signed [TW-1:0] tmin;
    logic signed [TW-1:0] tavg;
    logic [HW-1:0] hmax;
    logic [HW-1:0] hmin;
    logic [HW-1:0] havg;
    logic full;
    logic rolled;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HSUM, S_HRD, S_HDIV, S_DWR, S_DSUM, S_DRD, S_DDIV, S_OUT
  } st_t;
endpackage

// File: hdl/hdmms_front.sv
// Front end: accepts samples, counts them and flags roll-ups.
// Rebuilds the count phase after an interval write. Depends on hdmms_pkg.
module hdmms_front (
  input  logic clk,
  input  logic rst,
  input  logic [6:0] interval,
  input  logic cfg_load,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [hdmms_pkg::TW-1:0] temp,
  input  logic [hdmms_pkg::HW-1:0] hum,
  output logic q_valid,
  input  logic q_ready,
  output hdmms_pkg::job_t q_job
);
  logic [31:0] count;
  logic [31:0] count_next;
  logic [6:0] phase;
  logic [6:0] phase_next;
  logic roll;
  logic busy;
  logic [5:0] rstep;
  logic [31:0] rq;
  logic [7:0] rrem;
  logic [7:0] rrem_sh;

  // sample_count % interval tracked as a phase counter
  always_comb begin
    count_next = count + 32'd1;
    phase_next = phase + 7'd1;
    roll = 1'b0;
    if (count_next == 32'd0) begin
      roll = (interval != 7'd0);
      phase_next = 7'd0;
    end else if (phase_next == interval && interval != 7'd0) begin
      roll = 1'b1;
      phase_next = 7'd0;
    end else if (phase_next >= interval) begin
      phase_next = 7'd0;
    end
  end

  assign rrem_sh = {rrem[6:0], rq[31]};
  assign in_ready = !busy && (!q_valid || q_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 32'd0;
      phase <= 7'd0;
      q_valid <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (q_valid && q_ready) q_valid <= 1'b0;
      if (in_valid && in_ready) begin
        q_valid <= 1'b1;
        count <= count_next;
        phase <= phase_next;
        q_job <= '{temp: temp, hum: hum, roll: roll};
      end
      // rebuild the phase as count % interval, one bit per cycle
      if (cfg_load) begin
        busy <= 1'b1;
        rq <= count;
        rrem <= 8'd0;
        rstep <= 6'd0;
      end else if (busy) begin
        if (rstep != 6'd32) begin
          rrem <= (rrem_sh >= {1'b0, interval}) ? rrem_sh - {1'b0, interval} : rrem_sh;
          rq <= {rq[30:0], 1'b0};
          rstep <= rstep + 6'd1;
        end else begin
          phase <= rrem[6:0];
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: hdl/hdmms_back.sv
// Back end: hourly and daily rings, sums, divisions and result register.
// Depends on hdmms_pkg.
module hdmms_back #(
  parameter int HOUR_SLOTS = hdmms_pkg::HOUR_SLOTS_DEF,
  parameter int DAY_SLOTS = hdmms_pkg::DAY_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  hdmms_pkg::job_t q_job,
  output logic r_valid,
  input  logic r_ready,
  output hdmms_pkg::res_t r_res
);
  localparam int HA = (HOUR_SLOTS > 1) ? $clog2(HOUR_SLOTS) : 1;
  localparam int DA = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
  localparam int SW = 32;
  localparam int CW = 9;

  logic signed [hdmms_pkg::TW-1:0] hring_t [HOUR_SLOTS];
  logic [hdmms_pkg::HW-1:0] hring_h [HOUR_SLOTS];
  logic signed [hdmms_pkg::TW-1:0] dring_t [DAY_SLOTS];
  logic [hdmms_pkg::HW-1:0] dring_h [DAY_SLOTS];

  hdmms_pkg::st_t st, st_next;
  hdmms_pkg::job_t job;
  logic [HA-1:0] hidx;
  logic [DA-1:0] didx;
  logic dfull;
  logic [CW-1:0] cnt, n;
  logic signed [hdmms_pkg::TW-1:0] htmax, htmin, htavg, dtmax, dtmin, dtavg;
  logic signed [hdmms_pkg::TW-1:0] rd_t;
  logic [hdmms_pkg::HW-1:0] hhmax, hhmin, hhavg, dhmax, dhmin, dhavg, rd_h;
  logic signed [SW-1:0] sum_t, sum_h;
  logic rd_ok;
  // restoring divider on magnitudes
  logic [SW-1:0] qt, qh, rt, rh;
  logic neg_t;
  logic [5:0] dstep;
  logic [SW-1:0] rt_sh, rh_sh;
  logic [SW-1:0] nz;

  assign nz = SW'(n);

  always_comb begin
    st_next = st;
    case (st)
      hdmms_pkg::S_IDLE: if (q_valid) st_next = hdmms_pkg::S_HSUM;
      hdmms_pkg::S_HSUM: if (!rd_ok && cnt == n) st_next = hdmms_pkg::S_HDIV;
      hdmms_pkg::S_HDIV: if (dstep == 6'd32)
        st_next = job.roll ? hdmms_pkg::S_DWR : hdmms_pkg::S_OUT;
      hdmms_pkg::S_DWR: st_next = hdmms_pkg::S_DSUM;
      hdmms_pkg::S_DSUM: if (!rd_ok && cnt == n) st_next = hdmms_pkg::S_DDIV;
      hdmms_pkg::S_DDIV: if (dstep == 6'd32) st_next = hdmms_pkg::S_OUT;
      hdmms_pkg::S_OUT: if (!r_valid || r_ready) st_next = hdmms_pkg::S_IDLE;
      default: st_next = hdmms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (st == hdmms_pkg::S_IDLE);
  end

  always_comb begin
    rt_sh = {rt[SW-2:0], qt[SW-1]};
    rh_sh = {rh[SW-2:0], qh[SW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hdmms_pkg::S_IDLE;
      r_valid <= 1'b0;
      hidx <= '0;
      didx <= '0;
      dfull <= 1'b0;
      htmax <= '0; htmin <= hdmms_pkg::TW'(hdmms_pkg::MIN_START); htavg <= '0;
      hhmax <= '0; hhmin <= hdmms_pkg::HW'(hdmms_pkg::MIN_START); hhavg <= '0;
      dtmax <= '0; dtmin <= hdmms_pkg::TW'(hdmms_pkg::MIN_START); dtavg <= '0;
      dhmax <= '0; dhmin <= hdmms_pkg::HW'(hdmms_pkg::MIN_START); dhavg <= '0;
      rd_ok <= 1'b0;
    end else begin
      st <= st_next;
      if (r_valid && r_ready) r_valid <= 1'b0;
      case (st)
        hdmms_pkg::S_IDLE: if (st_next == hdmms_pkg::S_HSUM) begin
          job <= q_job;
          hring_t[hidx] <= q_job.temp;
          hring_h[hidx] <= q_job.hum;
          if (q_job.temp > htmax) htmax <= q_job.temp;
          if (q_job.temp < htmin) htmin <= q_job.temp;
          if (q_job.hum > hhmax) hhmax <= q_job.hum;
          if (q_job.hum < hhmin) hhmin <= q_job.hum;
          n <= CW'(hidx) + CW'(1);
          cnt <= '0;
          sum_t <= '0;
          sum_h <= '0;
          rd_ok <= 1'b0;
        end
        hdmms_pkg::S_HSUM, hdmms_pkg::S_DSUM: begin
          // read issued one cycle, accumulated the next
          if (rd_ok) begin
            sum_t <= sum_t + SW'(rd_t);
            sum_h <= sum_h + SW'(rd_h);
            if (st == hdmms_pkg::S_DSUM) begin
              if (rd_t > dtmax) dtmax <= rd_t;
              if (rd_t < dtmin) dtmin <= rd_t;
              if (rd_h > dhmax) dhmax <= rd_h;
              if (rd_h < dhmin) dhmin <= rd_h;
            end
          end
          if (cnt != n) begin
            if (st == hdmms_pkg::S_HSUM) begin
              rd_t <= hring_t[cnt[HA-1:0]];
              rd_h <= hring_h[cnt[HA-1:0]];
            end else begin
              rd_t <= dring_t[cnt[DA-1:0]];
              rd_h <= dring_h[cnt[DA-1:0]];
            end
            cnt <= cnt + CW'(1);
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
          end
          if (!rd_ok && cnt == n && (cnt != '0)) begin
            neg_t <= sum_t[SW-1];
            qt <= sum_t[SW-1] ? SW'(-sum_t) : SW'(sum_t);
            qh <= SW'(sum_h);
            rt <= '0;
            rh <= '0;
            dstep <= '0;
          end
        end
        hdmms_pkg::S_HDIV, hdmms_pkg::S_DDIV: begin
          if (dstep != 6'd32) begin
            if (rt_sh >= nz) begin
              rt <= rt_sh - nz; qt <= {qt[SW-2:0], 1'b1};
            end else begin
              rt <= rt_sh; qt <= {qt[SW-2:0], 1'b0};
            end
            if (rh_sh >= nz) begin
              rh <= rh_sh - nz; qh <= {qh[SW-2:0], 1'b1};
            end else begin
              rh <= rh_sh; qh <= {qh[SW-2:0], 1'b0};
            end
            dstep <= dstep + 6'd1;
          end else if (st == hdmms_pkg::S_HDIV) begin
            htavg <= hdmms_pkg::TW'(neg_t ? -qt : qt);
            hhavg <= hdmms_pkg::HW'(qh);
            hidx <= (int'(hidx) == HOUR_SLOTS - 1) ? '0 : hidx + HA'(1);
          end else begin
            dtavg <= hdmms_pkg::TW'(neg_t ? -qt : qt);
            dhavg <= hdmms_pkg::HW'(qh);
            if (int'(didx) == DAY_SLOTS - 1) begin
              didx <= '0;
              dfull <= 1'b1;
              dtmax <= '0; dtmin <= hdmms_pkg::TW'(hdmms_pkg::MIN_START);
              dhmax <= '0; dhmin <= hdmms_pkg::HW'(hdmms_pkg::MIN_START);
            end else begin
              didx <= didx + DA'(1);
            end
            hidx <= '0;
            htmax <= '0; htmin <= hdmms_pkg::TW'(hdmms_pkg::MIN_START); htavg <= '0;
            hhmax <= '0; hhmin <= hdmms_pkg::HW'(hdmms_pkg::MIN_START); hhavg <= '0;
          end
        end
        hdmms_pkg::S_DWR: begin
          dring_t[didx] <= htavg;
          dring_h[didx] <= hhavg;
          n <= dfull ? CW'(DAY_SLOTS) : CW'(didx) + CW'(1);
          cnt <= '0;
          sum_t <= '0;
          sum_h <= '0;
          rd_ok <= 1'b0;
        end
        hdmms_pkg::S_OUT: if (st_next == hdmms_pkg::S_IDLE) begin
          r_valid <= 1'b1;
          r_res.full <= dfull;
          r_res.rolled <= job.roll;
          if (dfull) begin
            r_res.tmax <= dtmax; r_res.tmin <= dtmin; r_res.tavg <= dtavg;
            r_res.hmax <= dhmax; r_res.hmin <= dhmin; r_res.havg <= dhavg;
          end else begin
            r_res.tmax <= htmax; r_res.tmin <= htmin; r_res.tavg <= htavg;
            r_res.hmax <= hhmax; r_res.hmin <= hhmin; r_res.havg <= hhavg;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/hourly_daily_min_max_avg_stats_core.sv
// Top level: one sample in, one statistics result out. Each result is set by a walk
// of the hourly ring and a 32-step division, plus a daily ring walk and a second
// division on a roll-up. The back end takes no new sample until its result is out;
// one sample is in the back end and one queued. An interval write holds input
// until the phase is rebuilt. rst is synchronous; it restores all statistics and
// sets the interval to 60. Depends on hdmms_pkg, hdmms_front, hdmms_back.
module hourly_daily_min_max_avg_stats_core #(
  parameter int HOUR_SLOTS = hdmms_pkg::HOUR_SLOTS_DEF,
  parameter int DAY_SLOTS = hdmms_pkg::DAY_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [31:0] s_tdata,   // temp_centi[14:0], hum_centi[28:15]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [87:0] m_tdata,   // temp max, min, avg; hum max, min, avg
  output logic [1:0] m_tuser     // day_window_full, rolled_up
);
  logic [6:0] interval;
  logic q_valid, q_ready;
  hdmms_pkg::job_t q_job;
  hdmms_pkg::res_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) interval <= hdmms_pkg::ROLLUP_RESET;
    else if (cfg_valid) interval <= cfg_data;
  end

  hdmms_front u_front (
    .clk, .rst, .interval,
    .cfg_load(cfg_valid && cfg_ready),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .temp(s_tdata[14:0]), .hum(s_tdata[28:15]),
    .q_valid, .q_ready, .q_job
  );

  hdmms_back #(.HOUR_SLOTS(HOUR_SLOTS), .DAY_SLOTS(DAY_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job,
    .r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
  );

  assign m_tdata = {1'b0, res.havg, res.hmin, res.hmax, res.tavg, res.tmin, res.tmax};
  assign m_tuser = {res.rolled, res.full};

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |=> !(m_tvalid && !m_tuser[0])) else $error("full dropped");
  a_q_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready) |=> q_valid) else $error("queue lost item");
endmodule
